/* rtl/core/mbclp_pkg.sv */
// ----------------------------------------------------------------------------
// mbclp_pkg
// shared constants and types for the multi-button click / long-press detector
// ----------------------------------------------------------------------------
package mbclp_pkg;

    // default sizing handed to the top level
    localparam int NUM_BUTTONS_DEF = 8;
    localparam int TIME_WIDTH_DEF  = 32;

    // events reported per tick at most
    localparam int MAX_RESULTS = 8;

    // configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // register widths
    localparam int DEB_W    = 16;
    localparam int LONG_W   = 24;
    localparam int MASK_W   = 8;
    localparam int USED_W   = 4;
    localparam int PERIOD_W = 10;

    // register reset values
    localparam logic [DEB_W-1:0]    DEB_RST    = DEB_W'(5);
    localparam logic [LONG_W-1:0]   LONG_RST   = LONG_W'(100);
    localparam logic [MASK_W-1:0]   MASK_RST   = '0;
    localparam logic [USED_W-1:0]   USED_RST   = '0;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(1);

    // output field widths
    localparam int LEVELS_W = 8;
    localparam int BIDX_W   = 3;
    localparam int TS_W     = 32;

    // register index in the address map (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_DEBOUNCE = 3'd0,
        REG_LONG     = 3'd1,
        REG_MASK     = 3'd2,
        REG_USED     = 3'd3,
        REG_PERIOD   = 3'd4
    } t_reg_idx;

    // event kind codes
    typedef enum logic {
        EVT_CLICK = 1'b0,
        EVT_LONG  = 1'b1
    } t_evt_kind;

endpackage

/* rtl/core/mbclp_ram.sv */
// ----------------------------------------------------------------------------
// mbclp_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module mbclp_ram #(
    parameter int WIDTH = 68,
    parameter int DEPTH = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/multi_button_click_long_press_top.sv */
// ----------------------------------------------------------------------------
// multi_button_click_long_press_top
// debounce plus click and long-press detection for up to NUM_BUTTONS buttons
// ----------------------------------------------------------------------------
// One input request is one tick carrying the raw level of every button. Each
// button is debounced (a level must stay quiet for the debounce time before it
// is taken), a taken release gives a click unless a long press was already
// reported, and a button held for the long-press time gives one long press.
// Events come out in button order, each stamped with tick number times
// tick_period_ms, and the final event of a tick carries last_of_tick. The
// first tick after reset only loads the levels and gives no event. All
// per-button state sits in one ram entry per button; a tick first does the
// timestamp multiply, then reads, updates and writes back each button in use
// over the single ram read port, then flushes the last event; it runs longer
// only while the result side stalls. The priming tick initializes every one
// of the NUM_BUTTONS ram entries. At most MAX_RESULTS events are reported per
// tick; later ones in that tick are dropped while the state still updates.
// Registers may be written only while no tick is in progress.
// ----------------------------------------------------------------------------
module multi_button_click_long_press_top #(
    parameter int NUM_BUTTONS = mbclp_pkg::NUM_BUTTONS_DEF,
    parameter int TIME_WIDTH  = mbclp_pkg::TIME_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // tick request channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [mbclp_pkg::LEVELS_W-1:0]    i_button_levels,
    // event request channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [mbclp_pkg::BIDX_W-1:0]      o_button_index,
    output logic                              o_event_kind,
    output logic [mbclp_pkg::TS_W-1:0]        o_timestamp_ms,
    output logic                              o_last_of_tick,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mbclp_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mbclp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mbclp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready
);

    import mbclp_pkg::*;

    localparam int IDX_W   = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int BEXT_W  = 6;                 // holds any button number up to 63
    localparam int CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam int ENTRY_W = 2 * TIME_WIDTH + 4;

    // entry layout: {prev_raw, edge_pending, edge_time, pressed, press_time, long_rep}
    localparam int LR_B    = 0;
    localparam int PT_LO   = 1;
    localparam int PR_B    = PT_LO + TIME_WIDTH;
    localparam int ET_LO   = PR_B + 1;
    localparam int PEND_B  = ET_LO + TIME_WIDTH;
    localparam int PREV_B  = PEND_B + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRIME,
        S_MUL,
        S_RD,
        S_EX,
        S_FLUSH
    } t_state;

    // event held back until we know whether it is the last of the tick
    typedef struct packed {
        logic              vld;
        logic [BIDX_W-1:0] idx;
        logic              kind;
    } t_hold;

    // configuration registers
    logic [DEB_W-1:0]    r_deb;
    logic [LONG_W-1:0]   r_long;
    logic [MASK_W-1:0]   r_mask;
    logic [USED_W-1:0]   r_used;
    logic [PERIOD_W-1:0] r_period;

    // sequencer
    t_state                r_state;
    logic                  r_primed;
    logic [TIME_WIDTH-1:0] r_tick;
    logic [LEVELS_W-1:0]   r_levels;
    logic [IDX_W-1:0]      r_idx;
    logic [TS_W-1:0]       r_ts;
    logic [CNT_W-1:0]      r_nevt;
    t_hold                 r_hold;

    // output register
    logic              r_out_vld;
    logic [BIDX_W-1:0] r_out_idx;
    logic              r_out_kind;
    logic [TS_W-1:0]   r_out_ts;
    logic              r_out_last;

    // ram ports
    logic               w_we;
    logic               w_re;
    logic [ENTRY_W-1:0] w_wdata;
    logic [ENTRY_W-1:0] w_rdata;

    // per-button datapath
    logic [BEXT_W-1:0]     w_bext;
    logic [BEXT_W-1:0]     w_nused;
    logic                  w_raw;
    logic                  w_press_lvl;
    logic [DEB_W-1:0]      w_deb;
    logic [LONG_W-1:0]     w_lng;
    logic                  w_prev_o;
    logic                  w_pend_o;
    logic [TIME_WIDTH-1:0] w_et_o;
    logic                  w_pr_o;
    logic [TIME_WIDTH-1:0] w_pt_o;
    logic                  w_lr_o;
    logic [TIME_WIDTH-1:0] w_edge_age;
    logic [TIME_WIDTH-1:0] w_press_age;
    logic                  w_edge_now;
    logic                  w_settle;
    logic                  w_change;
    logic                  w_press_acc;
    logic                  w_click;
    logic                  w_long;
    logic                  w_pend_n;
    logic [TIME_WIDTH-1:0] w_et_n;
    logic                  w_pr_n;
    logic [TIME_WIDTH-1:0] w_pt_n;
    logic                  w_lr_n;
    logic                  w_evt;
    logic                  w_out_free;
    logic                  w_out_load;
    logic                  w_stall;
    logic                  w_more;
    logic [TS_W-1:0]       w_now32;
    logic [TS_W+PERIOD_W-1:0] w_ts_full;

    logic     w_cfg_wr;
    t_reg_idx w_reg;

    // ---------------------------------------------------------------- config
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_reg    = t_reg_idx'(paddr[APB_ADDR_W-1:2]);

    always_comb begin
        unique case (w_reg)
            REG_DEBOUNCE: prdata = APB_DATA_W'(r_deb);
            REG_LONG:     prdata = APB_DATA_W'(r_long);
            REG_MASK:     prdata = APB_DATA_W'(r_mask);
            REG_USED:     prdata = APB_DATA_W'(r_used);
            REG_PERIOD:   prdata = APB_DATA_W'(r_period);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb    <= DEB_RST;
            r_long   <= LONG_RST;
            r_mask   <= MASK_RST;
            r_used   <= USED_RST;
            r_period <= PERIOD_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg)
                REG_DEBOUNCE: r_deb    <= pwdata[DEB_W-1:0];
                REG_LONG:     r_long   <= pwdata[LONG_W-1:0];
                REG_MASK:     r_mask   <= pwdata[MASK_W-1:0];
                REG_USED:     r_used   <= pwdata[USED_W-1:0];
                REG_PERIOD:   r_period <= pwdata[PERIOD_W-1:0];
                default:      ;
            endcase
        end
    end

    // ------------------------------------------------------- per-button state
    mbclp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_BUTTONS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_idx),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    // button number widened so buttons above eight read a low level
    assign w_bext      = BEXT_W'(r_idx);
    assign w_raw       = (w_bext < BEXT_W'(LEVELS_W)) ? r_levels[w_bext[BIDX_W-1:0]] : 1'b0;
    assign w_press_lvl = w_raw ^ ((w_bext < BEXT_W'(MASK_W)) && r_mask[w_bext[BIDX_W-1:0]]);

    // buttons in use, clipped to what the ram holds
    assign w_nused = (BEXT_W'(r_used) > BEXT_W'(NUM_BUTTONS)) ? BEXT_W'(NUM_BUTTONS)
                                                               : BEXT_W'(r_used);
    assign w_more  = (w_bext + BEXT_W'(1)) < w_nused;

    // zero durations act as one
    assign w_deb = (r_deb == '0) ? DEB_W'(1) : r_deb;
    assign w_lng = (r_long == '0) ? LONG_W'(1) : r_long;

    assign w_prev_o = w_rdata[PREV_B];
    assign w_pend_o = w_rdata[PEND_B];
    assign w_et_o   = w_rdata[ET_LO +: TIME_WIDTH];
    assign w_pr_o   = w_rdata[PR_B];
    assign w_pt_o   = w_rdata[PT_LO +: TIME_WIDTH];
    assign w_lr_o   = w_rdata[LR_B];

    assign w_edge_age  = r_tick - w_et_o;
    assign w_press_age = r_tick - w_pt_o;

    always_comb begin
        // a new edge restarts the window, which then cannot settle this tick
        w_edge_now  = w_raw != w_prev_o;
        w_settle    = !w_edge_now && w_pend_o &&
                      ({8'd0, w_edge_age} >= (TIME_WIDTH + 8)'(w_deb));
        w_change    = w_settle && (w_press_lvl != w_pr_o);
        w_press_acc = w_change && w_press_lvl;
        w_click     = w_change && !w_press_lvl && !w_lr_o;
        w_pend_n    = w_edge_now || (w_pend_o && !w_settle);
        w_et_n      = w_edge_now ? r_tick : w_et_o;
        w_pr_n      = w_change ? w_press_lvl : w_pr_o;
        w_pt_n      = w_press_acc ? r_tick : w_pt_o;
        // a freshly accepted press has zero age, so it never qualifies here
        w_long      = w_pr_n && !w_lr_o && !w_press_acc &&
                      ({8'd0, w_press_age} >= (TIME_WIDTH + 8)'(w_lng)) &&
                      (!w_pend_n || w_press_lvl);
        w_lr_n      = w_press_acc ? 1'b0 : (w_lr_o || w_long);
        w_evt       = (w_click || w_long) && (r_nevt < CNT_W'(MAX_RESULTS));
    end

    assign w_out_free = !r_out_vld || i_ready;
    assign w_stall    = w_evt && r_hold.vld && !w_out_free;

    // output register takes the held event this cycle
    assign w_out_load = ((r_state == S_EX) && !w_stall && w_evt && r_hold.vld) ||
                        ((r_state == S_FLUSH) && r_hold.vld && w_out_free);

    // ram control
    always_comb begin
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_wdata = {w_edge_now ? w_raw : w_prev_o, w_pend_n, w_et_n, w_pr_n, w_pt_n, w_lr_n};
        unique case (r_state)
            S_PRIME: begin
                w_we    = 1'b1;
                w_wdata = {w_raw, 1'b0, r_tick, w_press_lvl, r_tick, 1'b0};
            end
            S_MUL:   w_re = (w_nused != '0);
            S_RD:    w_re = 1'b1;
            S_EX:    w_we = !w_stall;
            default: ;
        endcase
    end

    // timestamp: low 32 bits of tick number times period
    assign w_now32   = TS_W'(r_tick);
    assign w_ts_full = (TS_W + PERIOD_W)'(w_now32) * (TS_W + PERIOD_W)'(r_period);

    assign o_ready = (r_state == S_IDLE);

    // ------------------------------------------------------------ sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_primed   <= 1'b0;
            r_tick     <= '0;
            r_idx      <= '0;
            r_nevt     <= '0;
            r_hold.vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            // output register drains on its own unless refilled
            if (r_out_vld && i_ready && !w_out_load) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_levels <= i_button_levels;
                        r_idx    <= '0;
                        r_nevt   <= '0;
                        r_state  <= r_primed ? S_MUL : S_PRIME;
                    end
                end

                S_PRIME: begin
                    if (r_idx == IDX_W'(NUM_BUTTONS - 1)) begin
                        r_primed <= 1'b1;
                        r_tick   <= r_tick + TIME_WIDTH'(1);
                        r_state  <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end

                S_MUL: begin
                    // read of button 0 was issued alongside
                    r_ts    <= w_ts_full[TS_W-1:0];
                    r_state <= (w_nused != '0) ? S_EX : S_FLUSH;
                end

                S_RD: r_state <= S_EX;

                S_EX: begin
                    if (!w_stall) begin
                        if (w_evt) begin
                            if (r_hold.vld) begin
                                r_out_vld  <= 1'b1;
                                r_out_idx  <= r_hold.idx;
                                r_out_kind <= r_hold.kind;
                                r_out_ts   <= r_ts;
                                r_out_last <= 1'b0;
                            end
                            r_hold.vld  <= 1'b1;
                            r_hold.idx  <= w_bext[BIDX_W-1:0];
                            r_hold.kind <= w_long ? EVT_LONG : EVT_CLICK;
                            r_nevt      <= r_nevt + CNT_W'(1);
                        end
                        if (w_more) begin
                            r_idx   <= r_idx + IDX_W'(1);
                            r_state <= S_RD;
                        end else begin
                            r_state <= S_FLUSH;
                        end
                    end
                end

                S_FLUSH: begin
                    if (!r_hold.vld) begin
                        r_tick  <= r_tick + TIME_WIDTH'(1);
                        r_state <= S_IDLE;
                    end else if (w_out_free) begin
                        r_out_vld  <= 1'b1;
                        r_out_idx  <= r_hold.idx;
                        r_out_kind <= r_hold.kind;
                        r_out_ts   <= r_ts;
                        r_out_last <= 1'b1;
                        r_hold.vld <= 1'b0;
                        r_tick     <= r_tick + TIME_WIDTH'(1);
                        r_state    <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_out_vld;
    assign o_button_index = r_out_idx;
    assign o_event_kind   = r_out_kind;
    assign o_timestamp_ms = r_out_ts;
    assign o_last_of_tick = r_out_last;

endmodule
